@@ sv/spqu_pkg.sv @@
// Shared constants, codes and types of the sorted priority queue with priority update.
package spqu_pkg;

    localparam int CAPACITY  = 16;
    localparam int KEY_BITS  = 16;
    localparam int PRIO_BITS = 16;

    localparam int IDX_W     = $clog2(CAPACITY + 1);

    localparam int REQ_W     = 3;
    localparam int KEY_W     = 16;
    localparam int PRIO_W    = 16;
    localparam int POS_W     = 5;
    localparam int CNT_W     = 5;

    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd5;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EVAL,
        FSM_APPLY
    } state_t;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic [KEY_W-1:0]         key;
        logic signed [PRIO_W-1:0] priority_req;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic [KEY_W-1:0]         key_out;
        logic signed [PRIO_W-1:0] priority_out;
        logic [POS_W-1:0]         position;
        logic [CNT_W-1:0]         count;
    } rsp_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]         key;
        logic signed [PRIO_BITS-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic             ins;
        logic [IDX_W-1:0] m;
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] count;
        entry_t           item;
    } cell_cmd_t;

    typedef struct packed {
        logic   match;
        logic   le;
        entry_t entry;
    } cell_view_t;

endpackage

@@ sv/spqu_cell.sv @@
// One slot of the sorted entry row: compares against the request and shifts with its neighbors.
module spqu_cell (
    input  logic                     clk,
    input  logic [spqu_pkg::IDX_W-1:0] idx,
    input  spqu_pkg::cell_cmd_t      cmd,
    input  spqu_pkg::entry_t         left_entry,
    input  spqu_pkg::entry_t         right_entry,
    output spqu_pkg::cell_view_t     view
);

    spqu_pkg::entry_t entry_reg;
    spqu_pkg::entry_t entry_next;
    logic             occupied;

    assign occupied   = idx < cmd.count;
    assign view.match = occupied && (entry_reg.key == cmd.item.key);
    assign view.le    = occupied && (entry_reg.prio <= cmd.item.prio);
    assign view.entry = entry_reg;

    always_comb
    begin
        priority if (!cmd.ins)
        begin
            entry_next = (idx < cmd.m) ? entry_reg : right_entry;
        end
        else if (idx < cmd.pos)
        begin
            entry_next = (idx < cmd.m) ? entry_reg : right_entry;
        end
        else if (idx == cmd.pos)
        begin
            entry_next = cmd.item;
        end
        else
        begin
            entry_next = (idx <= cmd.m) ? left_entry : entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

@@ sv/spqu_ctrl.sv @@
// Request sequencer: evaluates the cell row, drives the shift command and forms the result.
module spqu_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  spqu_pkg::req_t        req,
    output logic                  busy,
    output logic                  done,
    output spqu_pkg::rsp_t        rsp,
    output spqu_pkg::cell_cmd_t   cmd,
    input  spqu_pkg::cell_view_t  views [spqu_pkg::CAPACITY]
);

    localparam logic [spqu_pkg::IDX_W-1:0] NONE = spqu_pkg::IDX_W'(spqu_pkg::CAPACITY);

    spqu_pkg::state_t state_reg;
    spqu_pkg::state_t state_next;
    spqu_pkg::req_t   req_reg;
    spqu_pkg::rsp_t   rsp_reg;
    spqu_pkg::rsp_t   rsp_next;
    logic             done_reg;
    logic             done_next;

    logic [spqu_pkg::IDX_W-1:0] count_reg;
    logic [spqu_pkg::IDX_W-1:0] count_next;

    logic                                found_reg;
    logic [spqu_pkg::IDX_W-1:0]          m_reg;
    logic [spqu_pkg::IDX_W-1:0]          pos_reg;
    logic signed [spqu_pkg::PRIO_BITS-1:0] hit_prio_reg;

    logic                                found_eval;
    logic [spqu_pkg::IDX_W-1:0]          m_eval;
    logic [spqu_pkg::IDX_W-1:0]          pos_eval;
    logic [spqu_pkg::PRIO_BITS-1:0]      hit_prio_eval;
    logic [spqu_pkg::CAPACITY-1:0]       match_vec;
    logic [spqu_pkg::CAPACITY-1:0]       le_vec;

    logic [spqu_pkg::KEY_BITS-1:0]         k_req;
    logic signed [spqu_pkg::PRIO_BITS-1:0] p_req;
    logic                                  full;
    logic                                  empty;
    logic                                  we_apply;
    logic                                  ins_apply;
    logic [spqu_pkg::IDX_W-1:0]            m_apply;

    assign k_req = spqu_pkg::KEY_BITS'(req_reg.key);
    assign p_req = $signed(spqu_pkg::PRIO_BITS'($unsigned(req_reg.priority_req)));
    assign full  = count_reg >= NONE;
    assign empty = count_reg == '0;

    assign busy = state_reg != spqu_pkg::FSM_IDLE;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    always_comb
    begin
        m_eval        = '0;
        hit_prio_eval = '0;
        for (int i = 0; i < spqu_pkg::CAPACITY; i++)
        begin
            match_vec[i] = views[i].match;
            le_vec[i]    = views[i].le;
            if (views[i].match)
            begin
                m_eval        = m_eval | spqu_pkg::IDX_W'(i);
                hit_prio_eval = hit_prio_eval | views[i].entry.prio;
            end
        end
        found_eval = |match_vec;
        if (!found_eval)
        begin
            m_eval = NONE;
        end
        pos_eval = spqu_pkg::IDX_W'($countones(le_vec & ~match_vec));
    end

    always_comb
    begin
        unique case (state_reg)
            spqu_pkg::FSM_IDLE:
            begin
                state_next = start ? spqu_pkg::FSM_EVAL : spqu_pkg::FSM_IDLE;
            end
            spqu_pkg::FSM_EVAL:
            begin
                state_next = spqu_pkg::FSM_APPLY;
            end
            spqu_pkg::FSM_APPLY:
            begin
                state_next = spqu_pkg::FSM_IDLE;
            end
            default:
            begin
                state_next = spqu_pkg::FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        done_next  = 1'b0;
        we_apply   = 1'b0;
        ins_apply  = 1'b0;
        m_apply    = m_reg;
        rsp_next   = '0;
        if (state_reg == spqu_pkg::FSM_APPLY)
        begin
            done_next = 1'b1;
            unique case (req_reg.req_type)
                spqu_pkg::REQ_INSERT:
                begin
                    rsp_next.key_out      = spqu_pkg::KEY_W'(k_req);
                    rsp_next.priority_out = spqu_pkg::PRIO_W'(p_req);
                    if (found_reg || !full)
                    begin
                        we_apply          = 1'b1;
                        ins_apply         = 1'b1;
                        rsp_next.status   = spqu_pkg::STAT_OK;
                        rsp_next.position = spqu_pkg::POS_W'(pos_reg);
                        if (!found_reg)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        rsp_next.status = spqu_pkg::STAT_FULL;
                    end
                end
                spqu_pkg::REQ_REMOVE, spqu_pkg::REQ_LOOKUP:
                begin
                    rsp_next.key_out = spqu_pkg::KEY_W'(k_req);
                    if (found_reg)
                    begin
                        rsp_next.status       = spqu_pkg::STAT_OK;
                        rsp_next.priority_out = spqu_pkg::PRIO_W'(hit_prio_reg);
                        rsp_next.position     = spqu_pkg::POS_W'(m_reg);
                        if (req_reg.req_type == spqu_pkg::REQ_REMOVE)
                        begin
                            we_apply   = 1'b1;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        rsp_next.status = spqu_pkg::STAT_NOT_FOUND;
                    end
                end
                spqu_pkg::REQ_PEEK, spqu_pkg::REQ_POP:
                begin
                    if (empty)
                    begin
                        rsp_next.status = spqu_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        rsp_next.status       = spqu_pkg::STAT_OK;
                        rsp_next.key_out      = spqu_pkg::KEY_W'(views[0].entry.key);
                        rsp_next.priority_out = spqu_pkg::PRIO_W'(views[0].entry.prio);
                        if (req_reg.req_type == spqu_pkg::REQ_POP)
                        begin
                            we_apply   = 1'b1;
                            m_apply    = '0;
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                spqu_pkg::REQ_CLEAR:
                begin
                    rsp_next.status = spqu_pkg::STAT_OK;
                    count_next      = '0;
                end
                default:
                begin
                    rsp_next.status = spqu_pkg::STAT_OK;
                end
            endcase
            rsp_next.count = spqu_pkg::CNT_W'(count_next);
        end
    end

    always_comb
    begin
        cmd.we    = we_apply;
        cmd.ins   = ins_apply;
        cmd.m     = m_apply;
        cmd.pos   = pos_reg;
        cmd.count = count_reg;
        cmd.item  = '{key: k_req, prio: p_req};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spqu_pkg::FSM_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= req;
        end
        if (state_reg == spqu_pkg::FSM_EVAL)
        begin
            found_reg    <= found_eval;
            m_reg        <= m_eval;
            pos_reg      <= pos_eval;
            hit_prio_reg <= $signed(hit_prio_eval);
        end
        if (state_reg == spqu_pkg::FSM_APPLY)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

@@ sv/sorted_priority_queue_update.sv @@
// Top level of the sorted priority queue with priority update: a sequencer and a row of cells.
// A taken request passes through the compare and apply states before its result is shown, and no new
// request is taken until the block is idle again: compare all cells, shift the row, then show the result.
// A request may be taken in the same cycle in which the previous result is shown.
// Reset empties the queue at once by clearing the entry count; stored entries are not cleared.
// The receiver cannot stall, so each result is shown for exactly one cycle.
module sorted_priority_queue_update (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  spqu_pkg::req_t  req,
    output logic            busy,
    output logic            done,
    output spqu_pkg::rsp_t  rsp
);

    spqu_pkg::cell_cmd_t  cmd;
    spqu_pkg::cell_view_t views       [spqu_pkg::CAPACITY];
    spqu_pkg::entry_t     left_entries  [spqu_pkg::CAPACITY];
    spqu_pkg::entry_t     right_entries [spqu_pkg::CAPACITY];

    spqu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp),
        .cmd   (cmd),
        .views (views)
    );

    for (genvar g = 0; g < spqu_pkg::CAPACITY; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            assign left_entries[g] = views[g].entry;
        end
        else
        begin : g_inner_left
            assign left_entries[g] = views[g-1].entry;
        end
        if (g == spqu_pkg::CAPACITY - 1)
        begin : g_tail
            assign right_entries[g] = views[g].entry;
        end
        else
        begin : g_inner_right
            assign right_entries[g] = views[g+1].entry;
        end

        spqu_cell u_cell (
            .clk         (clk),
            .idx         (spqu_pkg::IDX_W'(g)),
            .cmd         (cmd),
            .left_entry  (left_entries[g]),
            .right_entry (right_entries[g]),
            .view        (views[g])
        );
    end

endmodule

@@ sv/spqu_checker.sv @@
// Port-level checks of the sorted priority queue and their binding to the top level.
module spqu_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input spqu_pkg::req_t  req,
    input logic            busy,
    input logic            done,
    input spqu_pkg::rsp_t  rsp
);

    localparam logic [spqu_pkg::CNT_W-1:0] CAP_CNT = spqu_pkg::CNT_W'(spqu_pkg::CAPACITY);

    a_result_after_three: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##3 done)
        else $error("No result three cycles after a request transfer.");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done)
        else $error("Block not busy in the cycle after a request transfer.");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("Result transfer while the block is still busy.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> rsp.count <= CAP_CNT)
        else $error("Entry count beyond capacity.");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status == spqu_pkg::STAT_FULL |-> rsp.count == CAP_CNT)
        else $error("Full status while the table is not full.");

endmodule

bind sorted_priority_queue_update spqu_checker u_spqu_checker (.*);

@@ bench/sorted_priority_queue_update_check.sv @@
// Checker that predicts every queue response and compares it with the one the block shows.
`timescale 1ns / 100ps

module sorted_priority_queue_update_check
    import spqu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  req_t req,
    input  logic done,
    input  rsp_t rsp,
    output int   failures,
    output int   pending
);

    logic [KEY_W-1:0]         held_key  [CAPACITY];
    logic signed [PRIO_W-1:0] held_prio [CAPACITY];
    int                       held;
    rsp_t                     awaited_rsp [$];
    int                       error_count;
    rsp_t                     want;
    rsp_t                     next_rsp;

    function automatic void drop_entry(input int idx);
        begin
            for (int i = idx; i + 1 < held; i++)
            begin
                held_key[i]  = held_key[i + 1];
                held_prio[i] = held_prio[i + 1];
            end
            held--;
        end
    endfunction

    function automatic int place_entry(input logic [KEY_W-1:0] k,
                                       input logic signed [PRIO_W-1:0] p);
        int slot;
        begin
            slot = 0;
            while (slot < held && held_prio[slot] <= p)
                slot++;
            for (int i = held; i > slot; i--)
            begin
                held_key[i]  = held_key[i - 1];
                held_prio[i] = held_prio[i - 1];
            end
            held_key[slot]  = k;
            held_prio[slot] = p;
            held++;
            return slot;
        end
    endfunction

    task automatic serve_request(input req_t r, output rsp_t e);
        int idx;
        int slot;
        begin
            e   = '0;
            idx = -1;
            for (int i = 0; i < held; i++)
                if (idx < 0 && held_key[i] == r.key)
                    idx = i;
            case (r.req_type)
                REQ_INSERT:
                begin
                    e.key_out      = r.key;
                    e.priority_out = r.priority_req;
                    if (idx < 0 && held >= CAPACITY)
                    begin
                        e.status = STAT_FULL;
                    end
                    else
                    begin
                        if (idx >= 0)
                            drop_entry(idx);
                        slot       = place_entry(r.key, r.priority_req);
                        e.status   = STAT_OK;
                        e.position = POS_W'(slot);
                    end
                end
                REQ_REMOVE, REQ_LOOKUP:
                begin
                    e.key_out = r.key;
                    if (idx < 0)
                    begin
                        e.status = STAT_NOT_FOUND;
                    end
                    else
                    begin
                        e.status       = STAT_OK;
                        e.priority_out = held_prio[idx];
                        e.position     = POS_W'(idx);
                        if (r.req_type == REQ_REMOVE)
                            drop_entry(idx);
                    end
                end
                REQ_PEEK, REQ_POP:
                begin
                    if (held == 0)
                    begin
                        e.status = STAT_EMPTY;
                    end
                    else
                    begin
                        e.status       = STAT_OK;
                        e.key_out      = held_key[0];
                        e.priority_out = held_prio[0];
                        if (r.req_type == REQ_POP)
                            drop_entry(0);
                    end
                end
                REQ_CLEAR:
                begin
                    held = 0;
                end
                default:
                begin
                end
            endcase
            e.count = CNT_W'(held);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held = 0;
            awaited_rsp.delete();
            error_count = 0;
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            if (done)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    $display("%0t: response with none outstanding: status %0d key %h prio %0d",
                             $time, rsp.status, rsp.key_out, rsp.priority_out);
                    error_count++;
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp.status !== want.status || rsp.key_out !== want.key_out ||
                        rsp.priority_out !== want.priority_out ||
                        rsp.position !== want.position || rsp.count !== want.count)
                    begin
                        $display("%0t: response differs: expected st %0d key %h prio %0d pos %0d cnt %0d",
                                 $time, want.status, want.key_out, want.priority_out,
                                 want.position, want.count);
                        $display("%0t:                   actual st %0d key %h prio %0d pos %0d cnt %0d",
                                 $time, rsp.status, rsp.key_out, rsp.priority_out,
                                 rsp.position, rsp.count);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                serve_request(req, next_rsp);
                awaited_rsp.push_back(next_rsp);
            end
            pending  <= awaited_rsp.size();
            failures <= error_count;
        end
    end

endmodule

@@ bench/sorted_priority_queue_update_test.sv @@
// Top of the bench: drives queue requests into the block and reports the verdict.
`timescale 1ns / 100ps

module sorted_priority_queue_update_test;
    import spqu_pkg::*;

    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;
    localparam int RANDOM_ITEMS = 500;
    localparam int QUIET_TAIL   = 60;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic done;
    rsp_t rsp;
    int   failures;
    int   pending;

    logic [KEY_W-1:0] key_pool [20];
    bit               gaps_on;

    sorted_priority_queue_update dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    sorted_priority_queue_update_check checker_inst (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .rsp      (rsp),
        .failures (failures),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("sorted_priority_queue_update: mismatch");
        $finish;
    end

    task automatic send(input logic [REQ_W-1:0] kind, input logic [KEY_W-1:0] k,
                        input logic signed [PRIO_W-1:0] p);
        req_t r;
        begin
            r.req_type     = kind;
            r.key          = k;
            r.priority_req = p;
            start <= 1'b1;
            req   <= r;
            @(posedge clk);
            while (busy)
                @(posedge clk);
        end
    endtask

    task automatic hold_off(input int n);
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        begin
            start <= 1'b0;
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
        end
    endtask

    task automatic send_random();
        int                       pick;
        logic [REQ_W-1:0]         kind;
        logic [KEY_W-1:0]         k;
        logic signed [PRIO_W-1:0] p;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                kind = REQ_INSERT;
            else if (pick < 57)
                kind = REQ_REMOVE;
            else if (pick < 65)
                kind = REQ_PEEK;
            else if (pick < 77)
                kind = REQ_POP;
            else if (pick < 79)
                kind = REQ_CLEAR;
            else if (pick < 95)
                kind = REQ_LOOKUP;
            else
                kind = ($urandom_range(0, 1) == 0) ? REQ_SPARE_LO : REQ_SPARE_HI;
            if ($urandom_range(0, 4) == 0)
                k = KEY_W'($urandom);
            else
                k = key_pool[$urandom_range(0, 19)];
            case ($urandom_range(0, 9))
                0: p = 16'sh8000;
                1: p = 16'sh7fff;
                2, 3, 4: p = PRIO_W'($urandom_range(0, 4)) - 16'sd2;
                default: p = PRIO_W'($urandom);
            endcase
            send(kind, k, p);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        req   <= '0;
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hffff;
        for (int i = 2; i < 20; i++)
            key_pool[i] = KEY_W'($urandom);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, missing keys and the spare request codes.
        send(REQ_PEEK, 16'h0000, 16'sd0);
        send(REQ_POP, 16'h0000, 16'sd0);
        send(REQ_REMOVE, 16'h1234, 16'sd0);
        send(REQ_LOOKUP, 16'hffff, 16'sd0);
        send(REQ_SPARE_LO, 16'habcd, 16'sh7fff);
        send(REQ_SPARE_HI, 16'h5432, 16'sh8000);

        // Fill to capacity with the priority extremes and runs of equal priorities.
        send(REQ_INSERT, 16'h0000, 16'sh8000);
        send(REQ_INSERT, 16'hffff, 16'sh7fff);
        for (int i = 1; i <= 14; i++)
            send(REQ_INSERT, KEY_W'(i), PRIO_W'(i % 3) - 16'sd1);

        // A new key is refused when full; a held key still updates.
        send(REQ_INSERT, 16'h8000, 16'sd0);
        send(REQ_INSERT, 16'h0005, 16'sh8000);
        send(REQ_LOOKUP, 16'h0005, 16'sd0);
        send(REQ_REMOVE, 16'hffff, 16'sd0);
        send(REQ_POP, 16'h0000, 16'sd0);
        send(REQ_PEEK, 16'h0000, 16'sd0);
        send(REQ_CLEAR, 16'h0000, 16'sd0);
        drain();

        gaps_on = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            if (n == RANDOM_ITEMS / 2)
                drain();
            if (gaps_on && n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 5) == 0)
                hold_off($urandom_range(1, 18));
            send_random();
        end

        drain();
        repeat (8) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("sorted_priority_queue_update: match");
        else
            $display("sorted_priority_queue_update: mismatch");
        $finish;
    end

endmodule

@@ sorted_priority_queue_update.f @@
sv/spqu_pkg.sv
sv/spqu_cell.sv
sv/spqu_ctrl.sv
sv/sorted_priority_queue_update.sv
sv/spqu_checker.sv
bench/sorted_priority_queue_update_check.sv
bench/sorted_priority_queue_update_test.sv
